[design/mcp_pkg.sv]
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared types, constants and lookup tables of the marching cubes polygoniser.
// ----------------------------------------------------------------------------
package mcp_pkg;

    // grid and value widths
    localparam int GRID_BITS  = 10;
    localparam int VALUE_BITS = 32;
    localparam int POS_W      = 32;
    localparam int STEP_W     = 31;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = GRID_BITS + 1 + STEP_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_EDGES  = 12;
    localparam int NUM_CORNERS = 8;
    localparam int EDGE_W     = 4;
    localparam int DIV_STEPS  = POS_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int ROW_DIG_W  = 60;
    localparam int ROW_W      = ROW_DIG_W + 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ISO_LEVEL = 3'd0,
        CFG_ORIGIN_X  = 3'd1,
        CFG_ORIGIN_Y  = 3'd2,
        CFG_ORIGIN_Z  = 3'd3,
        CFG_STEP_X    = 3'd4,
        CFG_STEP_Y    = 3'd5,
        CFG_STEP_Z    = 3'd6
    } t_cfg_idx;

    // request to the shared scale divider: floor(m * num / den)
    typedef struct packed {
        logic                  start;
        logic [POS_W-1:0]      m;
        logic [VALUE_BITS-1:0] num;
        logic [VALUE_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] q;
    } t_div_rsp;

    // corner offsets, packed as {z, y, x}
    localparam logic [2:0] CORNER_OFF [NUM_CORNERS] = '{
        3'b010, 3'b011, 3'b001, 3'b000, 3'b110, 3'b111, 3'b101, 3'b100
    };

    // edge endpoints ordered lower position first, and the axis it runs along
    localparam logic [2:0] EDGE_LO [NUM_EDGES] = '{
        3'd0, 3'd2, 3'd3, 3'd3, 3'd4, 3'd6, 3'd7, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3
    };
    localparam logic [2:0] EDGE_HI [NUM_EDGES] = '{
        3'd1, 3'd1, 3'd2, 3'd0, 3'd5, 3'd5, 3'd6, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7
    };
    localparam logic [1:0] EDGE_AXIS [NUM_EDGES] = '{
        2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2
    };

    // triangle table: {triangle count, edge digits right aligned, first edge highest}
    localparam logic [ROW_W-1:0] TRI_ROM [256] = '{
        {3'd0, 60'h0}, {3'd1, 60'h083}, {3'd1, 60'h019}, {3'd2, 60'h183981},
        {3'd1, 60'h12a}, {3'd2, 60'h08312a}, {3'd2, 60'h92a029}, {3'd3, 60'h2832a8a98},
        {3'd1, 60'h3b2}, {3'd2, 60'h0b28b0}, {3'd2, 60'h19023b}, {3'd3, 60'h1b219b98b},
        {3'd2, 60'h3a1ba3}, {3'd3, 60'h0a108a8ba}, {3'd3, 60'h3903b9ba9}, {3'd2, 60'h98aa8b},
        {3'd1, 60'h478}, {3'd2, 60'h430734}, {3'd2, 60'h019847}, {3'd3, 60'h419471731},
        {3'd2, 60'h12a847}, {3'd3, 60'h34730412a}, {3'd3, 60'h92a902847},
        {3'd4, 60'h2a9297273794},
        {3'd2, 60'h8473b2}, {3'd3, 60'hb47b24204}, {3'd3, 60'h90184723b},
        {3'd4, 60'h47b94b9b2921},
        {3'd3, 60'h3a13ba784}, {3'd4, 60'h1ba14b1047b4}, {3'd4, 60'h47890b9bab03},
        {3'd3, 60'h47b4b99ba},
        {3'd1, 60'h954}, {3'd2, 60'h954083}, {3'd2, 60'h054150}, {3'd3, 60'h854835315},
        {3'd2, 60'h12a954}, {3'd3, 60'h30812a495}, {3'd3, 60'h52a542402},
        {3'd4, 60'h2a5325354348},
        {3'd2, 60'h95423b}, {3'd3, 60'h0b208b495}, {3'd3, 60'h05401523b},
        {3'd4, 60'h21525828b485},
        {3'd3, 60'ha3ba13954}, {3'd4, 60'h49508181a8ba}, {3'd4, 60'h54050b5bab03},
        {3'd3, 60'h5485a8a8b},
        {3'd2, 60'h978579}, {3'd3, 60'h930953573}, {3'd3, 60'h078017157}, {3'd2, 60'h153357},
        {3'd3, 60'h978957a12}, {3'd4, 60'ha12950530573}, {3'd4, 60'h802825857a52},
        {3'd3, 60'h2a5253357},
        {3'd3, 60'h7957893b2}, {3'd4, 60'h95797292027b}, {3'd4, 60'h23b018178157},
        {3'd3, 60'hb21b17715},
        {3'd4, 60'h958857a13a3b}, {3'd5, 60'h5705097b010aba0}, {3'd5, 60'hba0b03a50807570},
        {3'd2, 60'hba57b5},
        {3'd1, 60'ha65}, {3'd2, 60'h0835a6}, {3'd2, 60'h9015a6}, {3'd3, 60'h1831985a6},
        {3'd2, 60'h165261}, {3'd3, 60'h165126308}, {3'd3, 60'h965906026},
        {3'd4, 60'h598582526328},
        {3'd2, 60'h23ba65}, {3'd3, 60'hb08b20a65}, {3'd3, 60'h01923b5a6},
        {3'd4, 60'h5a61929b298b},
        {3'd3, 60'h63b653513}, {3'd4, 60'h08b0b50515b6}, {3'd4, 60'h3b6036065059},
        {3'd3, 60'h65969bb98},
        {3'd2, 60'h5a6478}, {3'd3, 60'h43047365a}, {3'd3, 60'h1905a6847},
        {3'd4, 60'ha65197173794},
        {3'd3, 60'h612651478}, {3'd4, 60'h125526304347}, {3'd4, 60'h847905065026},
        {3'd5, 60'h739794329596269},
        {3'd3, 60'h3b2784a65}, {3'd4, 60'h5a647242027b}, {3'd4, 60'h01947823b5a6},
        {3'd5, 60'h9219b294b7b45a6},
        {3'd4, 60'h8473b53515b6}, {3'd5, 60'h51b5b610b7b404b}, {3'd5, 60'h059065036b63847},
        {3'd4, 60'h65969b4797b9},
        {3'd2, 60'ha4964a}, {3'd3, 60'h4a649a083}, {3'd3, 60'ha01a60640},
        {3'd4, 60'h83181686461a},
        {3'd3, 60'h149124264}, {3'd4, 60'h308129249264}, {3'd2, 60'h024426},
        {3'd3, 60'h832824426},
        {3'd3, 60'ha49a64b23}, {3'd4, 60'h08228b49a4a6}, {3'd4, 60'h3b201606461a},
        {3'd5, 60'h64161a48121b8b1},
        {3'd4, 60'h964936913b63}, {3'd5, 60'h8b1810b61914641}, {3'd3, 60'h3b6360064},
        {3'd2, 60'h648b68},
        {3'd3, 60'h7a678a89a}, {3'd4, 60'h0730a709a67a}, {3'd4, 60'ha671a7178180},
        {3'd3, 60'ha67a71173},
        {3'd4, 60'h126168189867}, {3'd5, 60'h269291679093739}, {3'd3, 60'h780706602},
        {3'd2, 60'h732672},
        {3'd4, 60'h23ba68a89867}, {3'd5, 60'h20727b09767a9a7}, {3'd5, 60'h1801781a767a23b},
        {3'd4, 60'hb21b17a61671},
        {3'd5, 60'h896867916b63136}, {3'd2, 60'h091b67}, {3'd4, 60'h7807063b0b60},
        {3'd1, 60'h7b6},
        {3'd1, 60'h76b}, {3'd2, 60'h308b76}, {3'd2, 60'h019b76}, {3'd3, 60'h819831b76},
        {3'd2, 60'ha126b7}, {3'd3, 60'h12a3086b7}, {3'd3, 60'h2902a96b7},
        {3'd4, 60'h6b72a3a83a98},
        {3'd2, 60'h723627}, {3'd3, 60'h708760620}, {3'd3, 60'h276237019},
        {3'd4, 60'h162186198876},
        {3'd3, 60'ha76a17137}, {3'd4, 60'ha7617a187108}, {3'd4, 60'h03707a0a96a7},
        {3'd3, 60'h76a7a88a9},
        {3'd2, 60'h684b86}, {3'd3, 60'h36b306046}, {3'd3, 60'h86b846901},
        {3'd4, 60'h946963931b36},
        {3'd3, 60'h6846b82a1}, {3'd4, 60'h12a30b06b046}, {3'd4, 60'h4b846b0292a9},
        {3'd5, 60'ha93a32943b36463},
        {3'd3, 60'h823842462}, {3'd2, 60'h042462}, {3'd4, 60'h190234246438},
        {3'd3, 60'h194142246},
        {3'd4, 60'h8138618466a1}, {3'd3, 60'ha10a06604}, {3'd5, 60'h4634386a3039a93},
        {3'd2, 60'ha946a4},
        {3'd2, 60'h49576b}, {3'd3, 60'h083495b76}, {3'd3, 60'h50154076b},
        {3'd4, 60'hb76834354315},
        {3'd3, 60'h954a1276b}, {3'd4, 60'h6b712a083495}, {3'd4, 60'h76b54a4a2402},
        {3'd5, 60'h348354325a52b76},
        {3'd3, 60'h723762549}, {3'd4, 60'h954086062687}, {3'd4, 60'h362376150540},
        {3'd5, 60'h628687218485158},
        {3'd4, 60'h954a16176137}, {3'd5, 60'h16a176107870954}, {3'd5, 60'h40a4a503a6a737a},
        {3'd4, 60'h76a7a854a48a},
        {3'd3, 60'h6956b9b89}, {3'd4, 60'h36b036056095}, {3'd4, 60'h0b805b01556b},
        {3'd3, 60'h6b3635531},
        {3'd4, 60'h12a95b9b8b56}, {3'd5, 60'h0b306b09656912a}, {3'd5, 60'hb85b56805a52025},
        {3'd4, 60'h6b36352a3a53},
        {3'd4, 60'h589528562382}, {3'd3, 60'h956960062}, {3'd5, 60'h158180568382628},
        {3'd2, 60'h156216},
        {3'd5, 60'h13616a386569896}, {3'd4, 60'ha10a06950560}, {3'd2, 60'h03856a},
        {3'd1, 60'ha56},
        {3'd2, 60'hb5a75b}, {3'd3, 60'hb5ab75830}, {3'd3, 60'h5b75ab190},
        {3'd4, 60'ha75ab7981831},
        {3'd3, 60'hb12b17751}, {3'd4, 60'h08312717572b}, {3'd4, 60'h9759279022b7},
        {3'd5, 60'h75272b592328982},
        {3'd3, 60'h25a235375}, {3'd4, 60'h820852875a25}, {3'd4, 60'h9015a35373a2},
        {3'd5, 60'h982921872a25752},
        {3'd2, 60'h135375}, {3'd3, 60'h087071175}, {3'd3, 60'h903935537},
        {3'd2, 60'h987597},
        {3'd3, 60'h5845a8ab8}, {3'd4, 60'h5045b05abb30}, {3'd4, 60'h01984a8aba45},
        {3'd5, 60'hab4a45b34941314},
        {3'd4, 60'h2512852b8458}, {3'd5, 60'h04b0b345b2b151b}, {3'd5, 60'h0250592b5458b85},
        {3'd2, 60'h9452b3},
        {3'd4, 60'h25a352345384}, {3'd3, 60'h5a2524420}, {3'd5, 60'h3a235a385458019},
        {3'd4, 60'h5a2524192942},
        {3'd3, 60'h845853351}, {3'd2, 60'h045105}, {3'd4, 60'h845853905035},
        {3'd1, 60'h945},
        {3'd3, 60'h4b749b9ab}, {3'd4, 60'h0834979b79ab}, {3'd4, 60'h1ab1b414074b},
        {3'd5, 60'h3143481a474bab4},
        {3'd4, 60'h4b79b492b912}, {3'd5, 60'h9749b791b2b1083}, {3'd3, 60'hb74b42240},
        {3'd4, 60'hb74b42834324},
        {3'd4, 60'h29a279237749}, {3'd5, 60'h9a7974a27870207}, {3'd5, 60'h37a3a274a1a040a},
        {3'd2, 60'h1a2874},
        {3'd3, 60'h491417713}, {3'd4, 60'h491417081871}, {3'd2, 60'h403743},
        {3'd1, 60'h487},
        {3'd2, 60'h9a8ab8}, {3'd3, 60'h30939bb9a}, {3'd3, 60'h01a0a88ab},
        {3'd2, 60'h31ab3a},
        {3'd3, 60'h12b1b99b8}, {3'd4, 60'h30939b1292b9}, {3'd2, 60'h02b80b},
        {3'd1, 60'h32b},
        {3'd3, 60'h23828aa89}, {3'd2, 60'h9a2092}, {3'd4, 60'h23828a0181a8},
        {3'd1, 60'h1a2},
        {3'd2, 60'h138918}, {3'd1, 60'h091}, {3'd1, 60'h038}, {3'd0, 60'h0}
    };

endpackage

[design/mcp_divider.sv]
// ----------------------------------------------------------------------------
// mcp_divider
// Serial shift-add scale unit: q = floor(m * num / den) for num <= den,
// one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mcp_divider import mcp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [POS_W-1:0]      r_m;
    logic [VALUE_BITS-1:0] r_n;
    logic [VALUE_BITS-1:0] r_d;
    logic [VALUE_BITS-1:0] r_r;
    logic [POS_W-1:0]      r_q;

    logic [VALUE_BITS:0]   w_r2;
    logic [VALUE_BITS:0]   w_r3;
    logic [VALUE_BITS:0]   w_r4;
    logic [VALUE_BITS:0]   w_r5;
    logic [VALUE_BITS:0]   w_dx;
    logic                  w_c1;
    logic                  w_c2;
    logic [POS_W-1:0]      w_q;

    // one step: double remainder, reduce, add numerator on a set bit, reduce
    always_comb begin
        w_dx = {1'b0, r_d};
        w_r2 = {r_r, 1'b0};
        w_c1 = (w_r2 >= w_dx);
        w_r3 = w_c1 ? (w_r2 - w_dx) : w_r2;
        w_r4 = w_r3 + (r_m[POS_W-1] ? {1'b0, r_n} : '0);
        w_c2 = r_m[POS_W-1] && (w_r4 >= w_dx);
        w_r5 = w_c2 ? (w_r4 - w_dx) : w_r4;
        w_q  = {r_q[POS_W-2:0], 1'b0} + POS_W'(w_c1) + POS_W'(w_c2);
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and remainder registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_m <= i_req.m;
            r_n <= i_req.num;
            r_d <= i_req.den;
            r_r <= '0;
            r_q <= '0;
        end else if (r_busy) begin
            r_m <= {r_m[POS_W-2:0], 1'b0};
            r_r <= w_r5[VALUE_BITS-1:0];
            r_q <= w_q;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

[design/mcp_edge_ram.sv]
// ----------------------------------------------------------------------------
// mcp_edge_ram
// Edge point store: interpolated axis coordinate of each crossed edge,
// one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mcp_edge_ram import mcp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [EDGE_W-1:0] i_waddr,
    input  logic [POS_W-1:0]  i_wdata,
    input  logic [EDGE_W-1:0] i_raddr,
    output logic [POS_W-1:0]  o_rdata
);

    logic [POS_W-1:0] r_mem [NUM_EDGES];
    logic [POS_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/marching_cubes_polygonise.sv]
// Order: corner positions, then crossed edges via the scale unit, then the triangles.
// Throughput: one cell at a time, paced by the one shared divider and by i_ready;
// o_ready stays low from acceptance until the last triangle transaction, or until
// the edge pass ends for a cell with no triangles.
// Reset: synchronous active-low i_rst_n; clears the sequencer, vertex counter
// and config registers (iso 0, origins 0, steps 1.0); the edge store is not cleared.
// ----------------------------------------------------------------------------
// marching_cubes_polygonise
// Marching cubes cell polygoniser: cube index, edge interpolation through a
// shared serial divider, and triangle emission from the triangle table.
// ----------------------------------------------------------------------------
module marching_cubes_polygonise import mcp_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    // cell input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [GRID_BITS-1:0]         i_cell_x,
    input  logic [GRID_BITS-1:0]         i_cell_y,
    input  logic [GRID_BITS-1:0]         i_cell_z,
    input  logic signed [VALUE_BITS-1:0] i_corner_value_0,
    input  logic signed [VALUE_BITS-1:0] i_corner_value_1,
    input  logic signed [VALUE_BITS-1:0] i_corner_value_2,
    input  logic signed [VALUE_BITS-1:0] i_corner_value_3,
    input  logic signed [VALUE_BITS-1:0] i_corner_value_4,
    input  logic signed [VALUE_BITS-1:0] i_corner_value_5,
    input  logic signed [VALUE_BITS-1:0] i_corner_value_6,
    input  logic signed [VALUE_BITS-1:0] i_corner_value_7,
    // triangle output channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [POS_W-1:0]      o_vert_a_x,
    output logic signed [POS_W-1:0]      o_vert_a_y,
    output logic signed [POS_W-1:0]      o_vert_a_z,
    output logic signed [POS_W-1:0]      o_vert_b_x,
    output logic signed [POS_W-1:0]      o_vert_b_y,
    output logic signed [POS_W-1:0]      o_vert_b_z,
    output logic signed [POS_W-1:0]      o_vert_c_x,
    output logic signed [POS_W-1:0]      o_vert_c_y,
    output logic signed [POS_W-1:0]      o_vert_c_z,
    output logic [31:0]                  o_base_index,
    output logic                         o_last_triangle
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_POS  = 8'b0000_0010,
        S_EDGE = 8'b0000_0100,
        S_PREP = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_RD   = 8'b0010_0000,
        S_CAP  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic signed [VALUE_BITS-1:0] r_iso;
    logic signed [POS_W-1:0]      r_org  [3];
    logic [STEP_W-1:0]            r_step [3];

    // cell registers
    logic [GRID_BITS-1:0]         r_cell [3];
    logic signed [VALUE_BITS-1:0] r_val  [NUM_CORNERS];
    logic [NUM_CORNERS-1:0]       r_cube;
    logic signed [POS_W-1:0]      r_pos  [3][2];

    // sequencer counters
    logic [1:0]        r_axis, n_axis;
    logic              r_off, n_off;
    logic [EDGE_W-1:0] r_edge, n_edge;
    logic [2:0]        r_tri, n_tri;
    logic [1:0]        r_vtx, n_vtx;
    logic [31:0]       r_vcount, n_vcount;
    logic [EDGE_W-1:0] r_redge;

    // interpolation operands
    logic signed [VALUE_BITS:0] r_num;
    logic signed [VALUE_BITS:0] r_den;
    logic [POS_W-1:0]           r_m;

    // triangle being assembled
    logic signed [POS_W-1:0] r_vert [3][3];

    logic [NUM_CORNERS-1:0]       w_cube;
    logic signed [VALUE_BITS-1:0] w_in_val [NUM_CORNERS];
    logic [GRID_BITS:0]           w_mul_a;
    logic [PROD_W-1:0]            w_prod;
    logic signed [SUM_W-1:0]      w_sum;
    logic signed [POS_W-1:0]      w_sat;
    logic [2:0]                   w_lo, w_hi;
    logic [1:0]                   w_ax;
    logic                         w_crossed;
    logic                         w_degen;
    logic [VALUE_BITS-1:0]        w_un, w_ud, w_unc;
    logic [ROW_W-1:0]             w_row;
    logic [2:0]                   w_ntri;
    logic [4:0]                   w_nib;
    logic [EDGE_W-1:0]            w_redge;
    logic [2:0]                   w_clo;
    logic                         w_last;
    logic                         w_edge_last;
    t_div_req                     w_div_req;
    t_div_rsp                     w_div_rsp;
    logic                         w_ram_we;
    logic [POS_W-1:0]             w_ram_wdata;
    logic [POS_W-1:0]             w_ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);

    // cube index from the incoming corner values
    always_comb begin
        w_in_val[0] = i_corner_value_0;
        w_in_val[1] = i_corner_value_1;
        w_in_val[2] = i_corner_value_2;
        w_in_val[3] = i_corner_value_3;
        w_in_val[4] = i_corner_value_4;
        w_in_val[5] = i_corner_value_5;
        w_in_val[6] = i_corner_value_6;
        w_in_val[7] = i_corner_value_7;
        for (int c = 0; c < NUM_CORNERS; c++) begin
            w_cube[c] = (w_in_val[c] < r_iso);
        end
    end

    // corner position: origin + (cell + offset) * step, saturated
    always_comb begin
        w_mul_a = {1'b0, r_cell[r_axis]} + (GRID_BITS + 1)'(r_off);
        w_prod  = PROD_W'(w_mul_a) * PROD_W'(r_step[r_axis]);
        w_sum   = SUM_W'(r_org[r_axis]) + $signed({2'b00, w_prod});
        if (!w_sum[SUM_W-1] && (|w_sum[SUM_W-2:POS_W-1])) begin
            w_sat = {1'b0, {(POS_W-1){1'b1}}};
        end else if (w_sum[SUM_W-1] && !(&w_sum[SUM_W-2:POS_W-1])) begin
            w_sat = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            w_sat = w_sum[POS_W-1:0];
        end
    end

    // edge decode and divider operand preparation
    always_comb begin
        w_lo        = EDGE_LO[r_edge];
        w_hi        = EDGE_HI[r_edge];
        w_ax        = EDGE_AXIS[r_edge];
        w_crossed   = r_cube[w_lo] ^ r_cube[w_hi];
        w_edge_last = (r_edge == EDGE_W'(NUM_EDGES - 1));
        w_degen     = (r_den == '0) || (r_num == '0) ||
                      (r_num[VALUE_BITS] != r_den[VALUE_BITS]);
        w_un        = r_num[VALUE_BITS] ? VALUE_BITS'(-r_num) : r_num[VALUE_BITS-1:0];
        w_ud        = r_den[VALUE_BITS] ? VALUE_BITS'(-r_den) : r_den[VALUE_BITS-1:0];
        w_unc       = (w_un > w_ud) ? w_ud : w_un;
        w_div_req.start = (r_state == S_PREP) && !w_degen;
        w_div_req.m     = r_m;
        w_div_req.num   = w_unc;
        w_div_req.den   = w_ud;
    end

    // edge store write: lower point, or lower point plus scaled step
    always_comb begin
        w_ram_we    = ((r_state == S_PREP) && w_degen) ||
                      ((r_state == S_DIV) && w_div_rsp.done);
        w_ram_wdata = (r_state == S_DIV) ? (r_pos[w_ax][0] + w_div_rsp.q) : r_pos[w_ax][0];
    end

    // triangle table row and current vertex edge
    always_comb begin
        w_row   = TRI_ROM[r_cube];
        w_ntri  = w_row[ROW_W-1:ROW_DIG_W];
        w_nib   = 5'(w_ntri) * 5'd3 - 5'd1 - 5'(r_tri) * 5'd3 - 5'(r_vtx);
        w_redge = EDGE_W'(w_row[ROW_DIG_W-1:0] >> {w_nib, 2'b00});
        w_last  = (r_tri == (w_ntri - 3'd1));
        w_clo   = EDGE_LO[r_redge];
    end

    mcp_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    mcp_edge_ram u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_edge),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_redge),
        .o_rdata (w_ram_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_off    = r_off;
        n_edge   = r_edge;
        n_tri    = r_tri;
        n_vtx    = r_vtx;
        n_vcount = r_vcount;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_POS;
                    n_axis  = 2'd0;
                    n_off   = 1'b0;
                end
            end
            S_POS: begin
                n_off = !r_off;
                if (r_off) begin
                    n_axis = r_axis + 2'd1;
                    if (r_axis == 2'd2) begin
                        n_state = S_EDGE;
                        n_edge  = '0;
                    end
                end
            end
            S_EDGE: begin
                if (w_crossed) begin
                    n_state = S_PREP;
                end else if (w_edge_last) begin
                    n_state = (w_ntri == 3'd0) ? S_IDLE : S_RD;
                    n_tri   = '0;
                    n_vtx   = '0;
                end else begin
                    n_edge = r_edge + 1'b1;
                end
            end
            S_PREP: begin
                if (!w_degen) begin
                    n_state = S_DIV;
                end else if (w_edge_last) begin
                    n_state = (w_ntri == 3'd0) ? S_IDLE : S_RD;
                    n_tri   = '0;
                    n_vtx   = '0;
                end else begin
                    n_state = S_EDGE;
                    n_edge  = r_edge + 1'b1;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    if (w_edge_last) begin
                        n_state = (w_ntri == 3'd0) ? S_IDLE : S_RD;
                        n_tri   = '0;
                        n_vtx   = '0;
                    end else begin
                        n_state = S_EDGE;
                        n_edge  = r_edge + 1'b1;
                    end
                end
            end
            S_RD: begin
                n_state = S_CAP;
            end
            S_CAP: begin
                if (r_vtx == 2'd2) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RD;
                    n_vtx   = r_vtx + 2'd1;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_vcount = r_vcount + 32'd3;
                    n_vtx    = '0;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RD;
                        n_tri   = r_tri + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= '0;
            r_off    <= 1'b0;
            r_edge   <= '0;
            r_tri    <= '0;
            r_vtx    <= '0;
            r_vcount <= '0;
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_off    <= n_off;
            r_edge   <= n_edge;
            r_tri    <= n_tri;
            r_vtx    <= n_vtx;
            r_vcount <= n_vcount;
        end
    end

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso <= '0;
            for (int k = 0; k < 3; k++) begin
                r_org[k]  <= '0;
                r_step[k] <= STEP_W'(65536);
            end
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ISO_LEVEL: r_iso     <= i_cfg_data[VALUE_BITS-1:0];
                CFG_ORIGIN_X:  r_org[0]  <= i_cfg_data[POS_W-1:0];
                CFG_ORIGIN_Y:  r_org[1]  <= i_cfg_data[POS_W-1:0];
                CFG_ORIGIN_Z:  r_org[2]  <= i_cfg_data[POS_W-1:0];
                CFG_STEP_X:    r_step[0] <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:    r_step[1] <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Z:    r_step[2] <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // cell capture, positions, operands and vertex assembly
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cell[0] <= i_cell_x;
            r_cell[1] <= i_cell_y;
            r_cell[2] <= i_cell_z;
            r_cube    <= w_cube;
            for (int c = 0; c < NUM_CORNERS; c++) begin
                r_val[c] <= w_in_val[c];
            end
        end
        if (r_state == S_POS) begin
            r_pos[r_axis][r_off] <= w_sat;
        end
        if (r_state == S_EDGE) begin
            r_num <= (VALUE_BITS + 1)'(r_iso) - (VALUE_BITS + 1)'(r_val[w_lo]);
            r_den <= (VALUE_BITS + 1)'(r_val[w_hi]) - (VALUE_BITS + 1)'(r_val[w_lo]);
            r_m   <= r_pos[w_ax][1] - r_pos[w_ax][0];
        end
        if (r_state == S_RD) begin
            r_redge <= w_redge;
        end
        if (r_state == S_CAP) begin
            for (int k = 0; k < 3; k++) begin
                r_vert[r_vtx][k] <= (EDGE_AXIS[r_redge] == 2'(k)) ? w_ram_rdata
                                    : r_pos[k][CORNER_OFF[w_clo][k]];
            end
        end
    end

    assign o_vert_a_x      = r_vert[0][0];
    assign o_vert_a_y      = r_vert[0][1];
    assign o_vert_a_z      = r_vert[0][2];
    assign o_vert_b_x      = r_vert[1][0];
    assign o_vert_b_y      = r_vert[1][1];
    assign o_vert_b_z      = r_vert[1][2];
    assign o_vert_c_x      = r_vert[2][0];
    assign o_vert_c_y      = r_vert[2][1];
    assign o_vert_c_z      = r_vert[2][2];
    assign o_base_index    = r_vcount;
    assign o_last_triangle = w_last;

`ifndef SYNTHESIS
    // each triangle transaction advances the vertex counter by three
    a_vcount_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> (r_vcount == $past(r_vcount) + 32'd3))
        else $error("vertex counter did not advance by three");

    // the last triangle of a cell frees the input side
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_triangle) |=> o_ready)
        else $error("not ready after last triangle");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside wait state");

    // edge store is written only during interpolation
    a_ram_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> ((r_state == S_PREP) || (r_state == S_DIV)))
        else $error("edge store written outside interpolation");
`endif

endmodule
